/* hdl/mer_pkg.sv */
// Shared types and constants for the midpoint ellipse rasterizer.
// Used by the command queue, the stepping engine and the top level.
`default_nettype none
package mer_pkg;

  localparam int RADIUS_BITS = 10;
  localparam int FLD_W       = 10;
  localparam int OUT_W       = 12;
  localparam int OFS_W       = RADIUS_BITS + 1;
  localparam int SQ_W        = 2 * RADIUS_BITS;
  localparam int QUAD_W      = 4 * RADIUS_BITS;
  localparam int MUL_W       = 2 * RADIUS_BITS + 4;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int DEC_W       = 4 * RADIUS_BITS + 8;
  localparam int BND_W       = 4 * RADIUS_BITS + 4;
  localparam int Q_DEPTH     = 2;
  localparam int Q_AW        = $clog2(Q_DEPTH);

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic {
    CMD_START,
    CMD_STEP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [FLD_W-1:0]         center_x;
    logic [FLD_W-1:0]         center_y;
    logic [RADIUS_BITS-1:0]   radius_x;
    logic [RADIUS_BITS-1:0]   radius_y;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A2,
    ST_B2,
    ST_A4,
    ST_A2B,
    ST_A2B2,
    ST_START_OUT,
    ST_EVAL,
    ST_ENT_SQX,
    ST_ENT_BX,
    ST_ENT_SQY,
    ST_ENT_AY,
    ST_ENT_SUM,
    ST_APPLY
  } state_t;

endpackage
`default_nettype wire

/* hdl/mer_front.sv */
// Front end: decodes input items into commands and holds them in a short queue.
// Depends on mer_pkg.
`default_nettype none
module mer_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           opcode,
  input  logic [mer_pkg::FLD_W-1:0]      center_x,
  input  logic [mer_pkg::FLD_W-1:0]      center_y,
  input  logic [mer_pkg::FLD_W-1:0]      radius_x,
  input  logic [mer_pkg::FLD_W-1:0]      radius_y,
  output logic                           cmd_valid,
  output mer_pkg::cmd_t                  cmd,
  input  logic                           cmd_pop
);
  import mer_pkg::*;

  cmd_t              queue [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr;
  logic [Q_AW-1:0]   rd_ptr;
  logic [Q_AW:0]     count;
  logic              push;
  cmd_t              item;

  always_comb begin
    item.kind     = (opcode == OP_START) ? CMD_START : CMD_STEP;
    item.center_x = center_x;
    item.center_y = center_y;
    item.radius_x = RADIUS_BITS'(radius_x);
    item.radius_y = RADIUS_BITS'(radius_y);
  end

  assign in_ready  = (count != (Q_AW+1)'(Q_DEPTH));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/mer_back.sv */
// Back end: setup sequencer with one shared multiplier, incremental stepping
// datapath and the result register. Depends on mer_pkg.
`default_nettype none
module mer_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  mer_pkg::cmd_t                  cmd,
  output logic                           cmd_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [mer_pkg::OUT_W-1:0] right_x,
  output logic signed [mer_pkg::OUT_W-1:0] left_x,
  output logic signed [mer_pkg::OUT_W-1:0] lower_y,
  output logic signed [mer_pkg::OUT_W-1:0] upper_y,
  output logic                           pixel_valid,
  output logic                           last
);
  import mer_pkg::*;

  state_t                   state;
  state_t                   state_next;

  logic [RADIUS_BITS-1:0]   ra;
  logic [RADIUS_BITS-1:0]   rb;
  logic [FLD_W-1:0]         cx;
  logic [FLD_W-1:0]         cy;
  logic [SQ_W-1:0]          a2;
  logic [SQ_W-1:0]          b2;
  logic [QUAD_W-1:0]        a4;
  logic [QUAD_W-1:0]        a2b2;
  logic [SQ_W:0]            s;
  logic [PROD_W-1:0]        prod;
  logic [BND_W-1:0]         bound;
  logic [BND_W-1:0]         bstep;
  logic [OFS_W-1:0]         x;
  logic [OFS_W-1:0]         y;
  logic signed [DEC_W-1:0]  d;
  logic signed [DEC_W-1:0]  p;
  logic signed [DEC_W-1:0]  r;
  logic signed [DEC_W-1:0]  qn;
  logic signed [DEC_W-1:0]  u;
  logic signed [DEC_W-1:0]  delta;
  logic                     xstep;
  logic                     ystep;
  logic                     region_two;
  logic                     finished;

  logic [MUL_W-1:0]         mul_a;
  logic [MUL_W-1:0]         mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic signed [DEC_W-1:0]  a2_d;
  logic signed [DEC_W-1:0]  b2_d;
  logic signed [DEC_W-1:0]  a2b2_d;
  logic signed [DEC_W-1:0]  prod_d;
  logic signed [DEC_W-1:0]  sel_a;
  logic signed [DEC_W-1:0]  sel_b;
  logic                     neg;
  logic                     enter_two;
  logic                     out_free;
  logic                     emit;
  logic                     emit_pix;
  logic [OFS_W-1:0]         x_nx;
  logic [OFS_W-1:0]         y_nx;
  logic [OFS_W-1:0]         ox;
  logic [OFS_W-1:0]         oy;

  assign a2_d    = $signed(DEC_W'(a2));
  assign b2_d    = $signed(DEC_W'(b2));
  assign a2b2_d  = $signed(DEC_W'(a2b2));
  assign prod_d  = $signed(DEC_W'(prod));
  assign neg     = d[DEC_W-1];
  assign enter_two = !region_two && (bound > BND_W'(a4));
  assign out_free  = !out_valid || out_ready;
  assign x_nx    = xstep ? x + 1'b1 : x;
  assign y_nx    = ystep ? y - 1'b1 : y;
  assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    sel_a = region_two ? (neg ? r : '0) : p;
    sel_b = region_two ? u : (neg ? '0 : qn);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_A2: begin
        mul_a = MUL_W'(ra);
        mul_b = MUL_W'(ra);
      end
      ST_B2: begin
        mul_a = MUL_W'(rb);
        mul_b = MUL_W'(rb);
      end
      ST_A4: begin
        mul_a = MUL_W'(a2);
        mul_b = MUL_W'(a2);
      end
      ST_A2B: begin
        mul_a = MUL_W'(a2);
        mul_b = MUL_W'(rb);
      end
      ST_A2B2: begin
        mul_a = MUL_W'(a2);
        mul_b = MUL_W'(b2);
      end
      ST_ENT_SQX: begin
        mul_a = MUL_W'({x, 1'b1});
        mul_b = MUL_W'({x, 1'b1});
      end
      ST_ENT_BX: begin
        mul_a = MUL_W'(b2);
        mul_b = prod[MUL_W-1:0];
      end
      ST_ENT_SQY: begin
        mul_a = MUL_W'(y - 1'b1);
        mul_b = MUL_W'(y - 1'b1);
      end
      ST_ENT_AY: begin
        mul_a = MUL_W'(a2);
        mul_b = prod[MUL_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    logic done;
    done       = 1'b0;
    state_next = state;
    cmd_pop    = 1'b0;
    emit       = 1'b0;
    emit_pix   = 1'b0;
    case (state)
      ST_IDLE:    done = 1'b1;
      ST_A2:      state_next = ST_B2;
      ST_B2:      state_next = ST_A4;
      ST_A4:      state_next = ST_A2B;
      ST_A2B:     state_next = ST_A2B2;
      ST_A2B2:    state_next = ST_START_OUT;
      ST_START_OUT: begin
        emit     = out_free;
        emit_pix = 1'b1;
        done     = out_free;
      end
      ST_EVAL: begin
        if (finished) begin
          emit = out_free;
          done = out_free;
        end else if (enter_two) begin
          state_next = ST_ENT_SQX;
        end else begin
          state_next = ST_APPLY;
        end
      end
      ST_ENT_SQX: state_next = ST_ENT_BX;
      ST_ENT_BX:  state_next = ST_ENT_SQY;
      ST_ENT_SQY: state_next = ST_ENT_AY;
      ST_ENT_AY:  state_next = ST_ENT_SUM;
      ST_ENT_SUM: state_next = ST_EVAL;
      ST_APPLY: begin
        emit     = out_free;
        emit_pix = 1'b1;
        done     = out_free;
      end
      default:    state_next = ST_IDLE;
    endcase
    if (done) begin
      if (cmd_valid) begin
        cmd_pop    = 1'b1;
        state_next = (cmd.kind == CMD_START) ? ST_A2 : ST_EVAL;
      end else begin
        state_next = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == CMD_START) begin
      ra <= cmd.radius_x;
      rb <= cmd.radius_y;
      cx <= cmd.center_x;
      cy <= cmd.center_y;
    end
    case (state)
      ST_A2:   a2 <= mul_p[SQ_W-1:0];
      ST_B2:   b2 <= mul_p[SQ_W-1:0];
      ST_A4: begin
        a4 <= mul_p[QUAD_W-1:0];
        s  <= (SQ_W+1)'(a2) + (SQ_W+1)'(b2);
      end
      ST_A2B: begin
        prod  <= mul_p;
        d     <= a2_d + (b2_d <<< 2);
        p     <= (b2_d <<< 3) + (b2_d <<< 2);
        r     <= b2_d <<< 3;
        bound <= BND_W'(s);
        bstep <= BND_W'(s) + (BND_W'(s) << 1);
      end
      ST_A2B2: begin
        a2b2 <= mul_p[QUAD_W-1:0];
        qn   <= (a2_d <<< 3) - (prod_d <<< 3);
        d    <= d - (prod_d <<< 2);
      end
      ST_START_OUT: begin
        if (out_free) begin
          u <= qn + (a2_d <<< 2);
          x <= '0;
          y <= OFS_W'(rb);
        end
      end
      ST_EVAL: begin
        delta <= sel_a + sel_b;
        xstep <= !region_two || neg;
        ystep <= region_two || !neg;
      end
      ST_ENT_SQX: prod <= mul_p;
      ST_ENT_BX:  prod <= mul_p;
      ST_ENT_SQY: begin
        d    <= prod_d - (a2b2_d <<< 2);
        prod <= mul_p;
      end
      ST_ENT_AY:  prod <= mul_p;
      ST_ENT_SUM: d <= d + (prod_d <<< 2);
      ST_APPLY: begin
        if (out_free) begin
          d <= d + delta;
          x <= x_nx;
          y <= y_nx;
          if (xstep) begin
            p     <= p + (b2_d <<< 3);
            r     <= r + (b2_d <<< 3);
            bound <= bound + bstep;
            bstep <= bstep + (BND_W'(s) << 1);
          end
          if (ystep) begin
            qn <= qn + (a2_d <<< 3);
            u  <= u + (a2_d <<< 3);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_two <= 1'b0;
      finished   <= 1'b1;
    end else begin
      case (state)
        ST_START_OUT: begin
          if (out_free) begin
            region_two <= 1'b0;
            finished   <= (rb == '0);
          end
        end
        ST_ENT_SUM: region_two <= 1'b1;
        ST_APPLY: begin
          if (out_free) begin
            finished <= (y_nx == '0);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (state == ST_START_OUT) begin
      ox = '0;
      oy = OFS_W'(rb);
    end else begin
      ox = x_nx;
      oy = y_nx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_valid <= emit_pix;
      if (emit_pix) begin
        right_x <= $signed(OUT_W'(cx) + OUT_W'(ox));
        left_x  <= $signed(OUT_W'(cx) - OUT_W'(ox));
        lower_y <= $signed(OUT_W'(cy) + OUT_W'(oy));
        upper_y <= $signed(OUT_W'(cy) - OUT_W'(oy));
        last    <= (state == ST_START_OUT) ? (rb == '0) : (y_nx == '0);
      end else begin
        right_x <= '0;
        left_x  <= '0;
        lower_y <= '0;
        upper_y <= '0;
        last    <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/midpoint_ellipse_rasterizer_core.sv */
// Midpoint ellipse rasterizer: one point of the first quadrant per step item,
// given as its four mirrored pixel coordinates.
//
// Input channel (in_valid/in_ready): opcode 0 loads center and semi-axes and
// returns the top point (0, radius_y); opcode 1 advances one point. Every item
// gives exactly one result on the output channel (out_valid/out_ready).
// Items pass through a two-entry command queue into the stepping engine, so
// the input keeps accepting while a result waits in the output register.
// A start makes five passes through the shared 24x24 multiplier. A step
// evaluates, then applies, and the engine takes the next item only once
// the result is emitted; the step on which the curve enters its second
// region first rebuilds the decision term with the multiplier (ENT_SQX to
// ENT_SUM) and then evaluates again.
// A step after the last point returns pixel_valid = 0, last = 1.
// Reset (rst, synchronous) empties the queue, drops any pending result and
// marks the ellipse finished. A waiting result holds while out_ready is low
// and the engine stalls before the next; the queue fills, then in_ready falls.
// Depends on mer_pkg, mer_front and mer_back.
`default_nettype none
module midpoint_ellipse_rasterizer_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             opcode,
  input  logic [mer_pkg::FLD_W-1:0]        center_x,
  input  logic [mer_pkg::FLD_W-1:0]        center_y,
  input  logic [mer_pkg::FLD_W-1:0]        radius_x,
  input  logic [mer_pkg::FLD_W-1:0]        radius_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [mer_pkg::OUT_W-1:0] right_x,
  output logic signed [mer_pkg::OUT_W-1:0] left_x,
  output logic signed [mer_pkg::OUT_W-1:0] lower_y,
  output logic signed [mer_pkg::OUT_W-1:0] upper_y,
  output logic                             pixel_valid,
  output logic                             last
);
  import mer_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  mer_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius_x  (radius_x),
    .radius_y  (radius_y),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  mer_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .right_x     (right_x),
    .left_x      (left_x),
    .lower_y     (lower_y),
    .upper_y     (upper_y),
    .pixel_valid (pixel_valid),
    .last        (last)
  );

endmodule
`default_nettype wire

/* hdl/mer_checker.sv */
// Port-level checks for the midpoint ellipse rasterizer, bound to the top level.
// Depends on mer_pkg.
`default_nettype none
module mer_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [mer_pkg::OUT_W-1:0] right_x,
  input logic signed [mer_pkg::OUT_W-1:0] left_x,
  input logic signed [mer_pkg::OUT_W-1:0] lower_y,
  input logic signed [mer_pkg::OUT_W-1:0] upper_y,
  input logic                             pixel_valid,
  input logic                             last
);
  import mer_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(right_x) && $stable(lower_y)
      && $stable(pixel_valid) && $stable(last))
    else $error("result changed while stalled");

  a_blank_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pixel_valid |-> last && right_x == '0 && left_x == '0
      && lower_y == '0 && upper_y == '0)
    else $error("blank result carries coordinates or no last");

  a_mirror: assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel_valid |-> right_x[0] == left_x[0] && lower_y[0] == upper_y[0])
    else $error("pixels not mirrored about a common center");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind midpoint_ellipse_rasterizer_core mer_checker u_mer_checker (.*);
`default_nettype wire
